>>> rtl/core/efs_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the EDF frame scheduler.
// No dependencies; the table, scan and top files import this package.
package efs_pkg;

	localparam int DL_W   = 26;
	localparam int TIME_W = 25;

	// Input command codes
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STEP  = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_TX_POWER    = 2'd0;
	localparam logic [1:0] CFG_FRAME_LIMIT = 2'd1;
	localparam logic [1:0] CFG_TASK_COUNT  = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [3:0]  slot;
		logic [15:0] task_id;
		logic [23:0] first_deadline;
		logic [23:0] period;
		logic [6:0]  cost;
	} cmd_item_t;

	typedef struct packed {
		logic [15:0] frame_task;
		logic [6:0]  frame_index;
		logic [23:0] job_number;
		logic [7:0]  frame_power;
		logic [15:0] missed_mask;
		logic        is_idle;
		logic        is_done;
		logic        feasible;
		logic        last;
	} frame_t;

	// Entry fields written only by a load.
	typedef struct packed {
		logic [15:0] id;
		logic [23:0] start_dl;
		logic [23:0] period;
		logic [6:0]  cost;
	} stat_entry_t;

	// Entry fields that change while a run is in progress.
	typedef struct packed {
		logic [DL_W-1:0] deadline;
		logic [23:0]     jobs;
	} dyn_entry_t;

	// Outcome of checking one slot during a scan.
	typedef struct packed {
		logic            missed;
		logic            released;
		logic [DL_W-1:0] deadline;
	} eval_res_t;

	typedef struct packed {
		logic busy;
		logic best_valid;
	} scan_stat_t;

	function automatic logic [DL_W-1:0] dl_add_sat(logic [DL_W-1:0] dl, logic [23:0] per);
		logic [DL_W:0] sum;
		sum = {1'b0, dl} + {3'b000, per};
		return sum[DL_W] ? {DL_W{1'b1}} : sum[DL_W-1:0];
	endfunction

endpackage

>>> rtl/core/efs_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interface used for the command and frame channels.
// The payload type is given per instance, normally a struct from efs_pkg.
interface efs_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/efs_table.sv
`timescale 1ns / 1ps
// Task table: one memory for load-time fields, one for run-time fields.
// Shared read address with registered read data; uses efs_pkg entry types.
module efs_table #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output efs_pkg::stat_entry_t stat_rd,
	output efs_pkg::dyn_entry_t  dyn_rd,
	input  logic                 stat_we,
	input  logic                 dyn_we,
	input  logic [AW-1:0]        wr_addr,
	input  efs_pkg::stat_entry_t stat_wdata,
	input  efs_pkg::dyn_entry_t  dyn_wdata
);
	import efs_pkg::*;

	stat_entry_t stat_mem [DEPTH];
	dyn_entry_t  dyn_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (stat_we) begin
			stat_mem[wr_addr] <= stat_wdata;
		end
		if (dyn_we) begin
			dyn_mem[wr_addr] <= dyn_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			stat_rd <= stat_mem[rd_addr];
			dyn_rd  <= dyn_mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/efs_scan.sv
`timescale 1ns / 1ps
// Per-slot scan unit: miss and release check on table read data, then a
// registered stage that keeps the earliest ready deadline. Uses efs_pkg.
module efs_scan #(
	parameter int AW = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 eval_valid,
	input  logic [AW-1:0]        eval_slot,
	input  efs_pkg::dyn_entry_t  dyn,
	input  efs_pkg::stat_entry_t stat,
	input  logic                 rdy,
	input  logic [24:0]          now,
	output efs_pkg::eval_res_t   res,
	output efs_pkg::scan_stat_t  status,
	output logic [AW-1:0]        best_slot
);
	import efs_pkg::*;

	logic [DL_W:0]   due;
	logic [DL_W:0]   rel_bound;
	logic            valid_s2;
	logic [AW-1:0]   slot_s2;
	logic [DL_W-1:0] dl_s2;
	logic            rdy_s2;
	logic            best_valid_q;
	logic [DL_W-1:0] best_dl_q;
	logic [AW-1:0]   best_slot_q;
	logic            take;

	// A waiting task is released once deadline - period <= now, which is
	// the same as deadline <= now + period (also covers deadline < period).
	always_comb begin
		due          = {1'b0, dyn.deadline} + {20'd0, stat.cost};
		rel_bound    = {2'b00, now} + {3'b000, stat.period};
		res.missed   = rdy && (due < {2'b00, now});
		res.released = !rdy && ({1'b0, dyn.deadline} <= rel_bound);
		res.deadline = res.missed ? dl_add_sat(dyn.deadline, stat.period) : dyn.deadline;
	end

	// Strict compare in ascending slot order keeps the lowest slot on a tie.
	assign take = valid_s2 && rdy_s2 && (!best_valid_q || (dl_s2 < best_dl_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			best_valid_q <= 1'b0;
		end else begin
			valid_s2 <= eval_valid;
			if (start) begin
				best_valid_q <= 1'b0;
			end else if (take) begin
				best_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (eval_valid) begin
			slot_s2 <= eval_slot;
			dl_s2   <= res.deadline;
			rdy_s2  <= rdy || res.released;
		end
		if (take) begin
			best_dl_q   <= dl_s2;
			best_slot_q <= slot_s2;
		end
	end

	assign status.busy       = valid_s2;
	assign status.best_valid = best_valid_q;
	assign best_slot         = best_slot_q;

endmodule

>>> rtl/core/edf_frame_scheduler_top.sv
`timescale 1ns / 1ps
// Top level of the EDF frame scheduler: command sequencer, ready flags,
// run state and frame output register. Uses efs_pkg, efs_stream_if,
// efs_table and efs_scan.
//
//   Channel   Dir   Handshake                 Payload
//   -------   ---   -----------------------   ------------------------------
//   cmd_ch    in    valid/ready               efs_pkg::cmd_item_t
//   frame_ch  out   valid/ready               efs_pkg::frame_t
//   cfg       in    cfg_we (no back-pressure) cfg_index, cfg_data
//
// A load, start or unknown command answers with a single frame; a start
// first rewrites every table entry. A step that runs a task scans N slots,
// looks up the chosen slot and then emits one frame per unit of its cost,
// and an idle step scans and emits a single idle frame, where N is
// task_count saturated at MAX_TASKS; the single read port of the task table,
// one slot per cycle, sets the scan length. A step at the frame limit emits
// a single done frame.
// Reset clears the ready flags, the time and the configuration and sets
// the block feasible; the table contents stay undefined until loaded.
// A stalled frame channel holds the sequencer only when it has a new frame
// to present; the last frame of a transaction waits in the output register
// while the next command is already accepted.
module edf_frame_scheduler_top #(
	parameter int MAX_TASKS = 16,
	parameter int MAX_COST  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	efs_stream_if.sink   cmd_ch,
	efs_stream_if.source frame_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import efs_pkg::*;

	localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CLEAR  = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_FETCH  = 3'd3;
	localparam logic [2:0] ST_UPDATE = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;
	localparam logic [2:0] ST_ONE    = 3'd6;

	// Configuration registers
	logic [7:0]          tx_power_q;
	logic [23:0]         frame_limit_q;
	logic [4:0]          task_count_q;

	// Run state
	logic [2:0]          state_q;
	logic [TIME_W-1:0]   now_q;
	logic                feas_q;
	logic [MAX_TASKS-1:0] rdy_q;
	logic [15:0]         mask_q;
	logic                one_idle_q;
	logic                one_done_q;

	// Sweep control: cnt_q issues table reads, slot_s1 follows the read data.
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       n_q;
	logic                s1_q;
	logic [AW-1:0]       slot_s1;

	// Job being emitted
	logic [15:0]         id_q;
	logic [6:0]          cost_q;
	logic [23:0]         jobs_q;
	logic [6:0]          f_q;

	logic                out_valid_q;
	frame_t              out_q;

	// Datapath
	cmd_item_t           item;
	logic                cmd_acc;
	logic                slot_ok;
	logic [AW-1:0]       load_addr;
	logic [6:0]          load_cost;
	logic [CW-1:0]       n_eff;
	logic                issue;
	logic                scan_eval;
	logic                out_free;
	logic                out_load;
	logic                at_limit;
	logic [23:0]         jobs_inc;

	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	stat_entry_t         stat_rd;
	dyn_entry_t          dyn_rd;
	logic                stat_we;
	logic                dyn_we;
	logic [AW-1:0]       wr_addr;
	stat_entry_t         stat_wdata;
	dyn_entry_t          dyn_wdata;

	eval_res_t           upd;
	scan_stat_t          scan_st;
	logic [AW-1:0]       best_slot;

	assign item      = cmd_ch.payload;
	assign cmd_ch.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd_ch.valid && cmd_ch.ready;
	assign slot_ok   = int'(item.slot) < MAX_TASKS;
	assign load_addr = AW'(item.slot);
	assign load_cost = (item.cost == 7'd0) ? 7'd1 :
	                   (int'(item.cost) > MAX_COST) ? 7'(MAX_COST) : item.cost;
	assign n_eff     = (int'(task_count_q) > MAX_TASKS) ? CW'(MAX_TASKS) : CW'(task_count_q);
	assign at_limit  = now_q >= {1'b0, frame_limit_q};

	// Table reads go out one slot per cycle during a start sweep or a scan.
	assign issue     = ((state_q == ST_CLEAR) || (state_q == ST_SCAN)) && (cnt_q < n_q);
	assign scan_eval = s1_q && (state_q == ST_SCAN);
	assign out_free  = !out_valid_q || frame_ch.ready;
	// A new frame enters the output register in this cycle.
	assign out_load  = ((state_q == ST_EMIT) || (state_q == ST_ONE)) && out_free;
	assign jobs_inc  = (dyn_rd.jobs == 24'hFFFFFF) ? dyn_rd.jobs : dyn_rd.jobs + 24'd1;

	assign frame_ch.valid   = out_valid_q;
	assign frame_ch.payload = out_q;

	// Table port control. Reads and writes never meet on the same entry:
	// a sweep writes slot i while it reads slot i + 1, and the lookup of the
	// chosen slot starts only after the scan has drained.
	always_comb begin
		rd_en      = 1'b0;
		rd_addr    = cnt_q[AW-1:0];
		stat_we    = 1'b0;
		dyn_we     = 1'b0;
		wr_addr    = slot_s1;
		stat_wdata = '{id: item.task_id, start_dl: item.first_deadline,
		               period: item.period, cost: load_cost};
		dyn_wdata  = '{deadline: {2'b00, stat_rd.start_dl}, jobs: 24'd0};
		if (issue) begin
			rd_en = 1'b1;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc && (item.cmd == CMD_LOAD) && slot_ok) begin
					stat_we   = 1'b1;
					dyn_we    = 1'b1;
					wr_addr   = load_addr;
					dyn_wdata = '{deadline: {2'b00, item.first_deadline}, jobs: 24'd0};
				end
			end
			ST_CLEAR: begin
				dyn_we = s1_q;
			end
			ST_SCAN: begin
				dyn_we    = s1_q && upd.missed;
				dyn_wdata = '{deadline: upd.deadline, jobs: dyn_rd.jobs};
			end
			ST_FETCH: begin
				rd_en   = 1'b1;
				rd_addr = best_slot;
			end
			ST_UPDATE: begin
				dyn_we    = 1'b1;
				wr_addr   = best_slot;
				dyn_wdata = '{deadline: dl_add_sat(dyn_rd.deadline, stat_rd.period),
				              jobs: jobs_inc};
			end
			default: begin
			end
		endcase
	end

	efs_table #(
		.DEPTH (MAX_TASKS),
		.AW    (AW)
	) u_table (
		.clk        (clk),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.stat_rd    (stat_rd),
		.dyn_rd     (dyn_rd),
		.stat_we    (stat_we),
		.dyn_we     (dyn_we),
		.wr_addr    (wr_addr),
		.stat_wdata (stat_wdata),
		.dyn_wdata  (dyn_wdata)
	);

	efs_scan #(
		.AW (AW)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (cmd_acc),
		.eval_valid (scan_eval),
		.eval_slot  (slot_s1),
		.dyn        (dyn_rd),
		.stat       (stat_rd),
		.rdy        (rdy_q[slot_s1]),
		.now        (now_q),
		.res        (upd),
		.status     (scan_st),
		.best_slot  (best_slot)
	);

	// Sequencer and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_power_q    <= '0;
			frame_limit_q <= '0;
			task_count_q  <= '0;
			state_q       <= ST_IDLE;
			now_q         <= '0;
			feas_q        <= 1'b1;
			rdy_q         <= '0;
			mask_q        <= '0;
			one_idle_q    <= 1'b0;
			one_done_q    <= 1'b0;
			cnt_q         <= '0;
			n_q           <= '0;
			s1_q          <= 1'b0;
			f_q           <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_TX_POWER:    tx_power_q    <= cfg_data[7:0];
					CFG_FRAME_LIMIT: frame_limit_q <= cfg_data;
					CFG_TASK_COUNT:  task_count_q  <= cfg_data[4:0];
					default: begin
					end
				endcase
			end

			s1_q <= issue;
			if (issue) begin
				cnt_q <= cnt_q + CW'(1);
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (frame_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			// Miss and release results of the slot in the check stage.
			if (scan_eval && upd.missed) begin
				mask_q <= mask_q | (16'd1 << slot_s1);
				feas_q <= 1'b0;
			end
			if (scan_eval && upd.released) begin
				rdy_q[slot_s1] <= 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						mask_q     <= '0;
						one_idle_q <= 1'b0;
						one_done_q <= 1'b0;
						unique case (item.cmd)
							CMD_LOAD: begin
								if (slot_ok) begin
									rdy_q[load_addr] <= 1'b1;
								end
								state_q <= ST_ONE;
							end
							CMD_START: begin
								rdy_q   <= '1;
								now_q   <= '0;
								feas_q  <= 1'b1;
								cnt_q   <= '0;
								n_q     <= CW'(MAX_TASKS);
								state_q <= ST_CLEAR;
							end
							CMD_STEP: begin
								if (at_limit) begin
									one_done_q <= 1'b1;
									state_q    <= ST_ONE;
								end else begin
									cnt_q   <= '0;
									n_q     <= n_eff;
									state_q <= ST_SCAN;
								end
							end
							default: begin
								state_q <= ST_ONE;
							end
						endcase
					end
				end
				ST_CLEAR: begin
					if (!issue && !s1_q) begin
						state_q <= ST_ONE;
					end
				end
				ST_SCAN: begin
					if (!issue && !s1_q && !scan_st.busy) begin
						if (scan_st.best_valid) begin
							state_q <= ST_FETCH;
						end else begin
							// Nothing ready: one idle frame passes.
							now_q      <= now_q + 25'd1;
							one_idle_q <= 1'b1;
							state_q    <= ST_ONE;
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					rdy_q[best_slot] <= 1'b0;
					now_q            <= now_q + {18'd0, stat_rd.cost};
					f_q              <= 7'd1;
					state_q          <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						f_q <= f_q + 7'd1;
						if (f_q == cost_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_ONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (issue) begin
			slot_s1 <= cnt_q[AW-1:0];
		end
		if (state_q == ST_UPDATE) begin
			id_q   <= stat_rd.id;
			cost_q <= stat_rd.cost;
			jobs_q <= jobs_inc;
		end
		if ((state_q == ST_EMIT) && out_free) begin
			out_q <= '{frame_task: id_q, frame_index: f_q, job_number: jobs_q,
			           frame_power: tx_power_q,
			           missed_mask: (f_q == 7'd1) ? mask_q : 16'd0,
			           is_idle: 1'b0, is_done: 1'b0, feasible: feas_q,
			           last: (f_q == cost_q)};
		end else if ((state_q == ST_ONE) && out_free) begin
			out_q <= '{frame_task: 16'd0, frame_index: 7'd0, job_number: 24'd0,
			           frame_power: 8'd0, missed_mask: mask_q,
			           is_idle: one_idle_q, is_done: one_done_q, feasible: feas_q,
			           last: 1'b1};
		end
	end

	// The sweeps never read an entry in the cycle it is written.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && dyn_we) |-> (rd_addr != wr_addr))
		else $error("task table read and write hit the same entry");

	// A new command never arrives while slot checks are still in flight.
	a_scan_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |-> (!s1_q && !scan_st.busy))
		else $error("command accepted with the scan pipeline busy");

	// The frame counter stays within the job while frames go out.
	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> ((f_q != 7'd0) && (f_q <= cost_q)))
		else $error("frame index outside the job");

	// Once a miss has cleared feasibility only a start sets it again.
	a_feas_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(!feas_q && !(cmd_acc && (item.cmd == CMD_START))) |=> !feas_q)
		else $error("feasibility set again without a start");

endmodule
